[rtl/dssw_pkg.sv]
// ----------------------------------------------------------------------------
// dssw_pkg
// Shared types, constants and segment tables for the decimal display writer.
// ----------------------------------------------------------------------------
package dssw_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int BCD_W       = DIGIT_COUNT * 4;
  localparam int VALUE_W     = 32;
  localparam int BIT_CNT_W   = $clog2(VALUE_W);

  localparam logic [VALUE_W-1:0] FULL_MAX = VALUE_W'(10 ** DIGIT_COUNT - 1);
  localparam logic [VALUE_W-1:0] NEG_MAX  = VALUE_W'(10 ** (DIGIT_COUNT - 1) - 1);

  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] SEG_MINUS = 8'h40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // "Error" followed by blanks
  function automatic logic [7:0] error_seg(input logic [2:0] j);
    logic [7:0] s;
    unique case (j)
      3'd0:    s = 8'h79;
      3'd1:    s = 8'h50;
      3'd2:    s = 8'h50;
      3'd3:    s = 8'h5C;
      3'd4:    s = 8'h50;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[rtl/decimal_to_seven_segment_writer.sv]
// ----------------------------------------------------------------------------
// decimal_to_seven_segment_writer
// Converts a number to decimal with a bit-serial double-dabble and emits one
// display-RAM write per digit position.
// ----------------------------------------------------------------------------
// channel   handshake            payload
// in        in_valid/in_ready    action, value, dot_mask
// out       out_valid/out_ready  grid_address, segments, last_write
//
// a number goes through a load in idle, the double-dabble loop with one shift
// per magnitude bit, then one write per cycle while out_ready is high.
// an out-of-range number skips the conversion and goes straight to the writes.
// in_ready is high only in idle; a stall on out_ready holds the current write.
// rst clears the state machine; the datapath registers need no reset.
// ----------------------------------------------------------------------------
module decimal_to_seven_segment_writer
  import dssw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [VALUE_W-1:0] value,
  input  logic [7:0]         dot_mask,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         grid_address,
  output logic [7:0]         segments,
  output logic               last_write
);

  state_t               state, state_next;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]     idx;
  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [7:0]           dots;
  logic                 err;
  logic                 neg;

  logic                 in_neg;
  logic [VALUE_W-1:0]   in_mag;
  logic                 in_err;
  logic                 last_idx;
  logic [IDX_W-1:0]     pos;

  assign in_neg   = action & value[VALUE_W-1];
  assign in_mag   = in_neg ? (~value + VALUE_W'(1)) : value;
  assign in_err   = in_neg ? (in_mag > NEG_MAX) : (value > FULL_MAX);
  assign last_idx = (idx == IDX_W'(DIGIT_COUNT - 1));

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = in_err ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && last_idx) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mag     <= in_mag;
          bcd     <= '0;
          dots    <= dot_mask;
          err     <= in_err;
          neg     <= in_neg;
          bit_cnt <= '0;
          idx     <= '0;
        end
      end
      ST_CONV: begin
        bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
        mag     <= {mag[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_ready) begin
          bcd  <= {4'd0, bcd[BCD_W-1:4]};
          dots <= {1'b0, dots[7:1]};
          idx  <= idx + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // error pattern runs left to right, digits run right to left
  assign pos          = err ? idx : (IDX_W'(DIGIT_COUNT - 1) - idx);
  assign grid_address = 4'({pos, 1'b0});
  assign last_write   = last_idx;

  always_comb begin
    if (err) begin
      segments = error_seg(3'(idx));
    end else if (neg && last_idx) begin
      segments = SEG_MINUS;
    end else if (dots[0]) begin
      segments = digit_seg(bcd[3:0]) | SEG_POINT;
    end else begin
      segments = digit_seg(bcd[3:0]);
    end
  end

endmodule

[verif/display_write_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_write_check
// Watches both channels of the display writer, works out the display writes
// each accepted number should cause and compares every accepted write with
// the oldest one still owed.
// ----------------------------------------------------------------------------
module display_write_check
  import dssw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic [VALUE_W-1:0] value,
  input  logic [7:0]         dot_mask,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         grid_address,
  input  logic [7:0]         segments,
  input  logic               last_write,
  output int unsigned        mismatch_count,
  output int unsigned        writes_outstanding
);

  typedef struct packed {
    logic [3:0] grid;
    logic [7:0] seg;
    logic       last;
  } disp_write_t;

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  // E r r o r, then blanks
  localparam logic [7:0] ERROR_GLYPH [8] = '{
    8'h79, 8'h50, 8'h50, 8'h5C, 8'h50, 8'h00, 8'h00, 8'h00
  };

  disp_write_t pending_writes[$];

  function automatic void predict_display_writes(input logic               act,
                                                 input logic [VALUE_W-1:0] val,
                                                 input logic [7:0]         dots);
    logic [VALUE_W-1:0] mag;
    logic               negative;
    logic               overflow;
    int                 ndig;
    disp_write_t        w;
    negative = act && val[VALUE_W-1];
    mag      = negative ? (VALUE_W'(0) - val) : val;
    overflow = negative ? (mag > NEG_MAX) : (val > FULL_MAX);
    if (overflow) begin
      for (int j = 0; j < DIGIT_COUNT; j++) begin
        w.grid = 4'(j * 2);
        w.seg  = ERROR_GLYPH[j];
        w.last = (j == DIGIT_COUNT - 1);
        pending_writes.push_back(w);
      end
      return;
    end
    // rightmost digit first; a negative number gives up the leftmost place
    ndig = negative ? DIGIT_COUNT - 1 : DIGIT_COUNT;
    for (int i = 0; i < ndig; i++) begin
      w.grid = 4'((DIGIT_COUNT - 1 - i) * 2);
      w.seg  = DIGIT_GLYPH[mag % 10];
      if (dots[i]) w.seg = w.seg | SEG_POINT;
      w.last = !negative && (i == ndig - 1);
      pending_writes.push_back(w);
      mag = mag / 10;
    end
    if (negative) begin
      w.grid = 4'd0;
      w.seg  = SEG_MINUS;
      w.last = 1'b1;
      pending_writes.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    disp_write_t got;
    disp_write_t want;
    if (rst) begin
      pending_writes.delete();
      mismatch_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.grid = grid_address;
        got.seg  = segments;
        got.last = last_write;
        if (pending_writes.size() == 0) begin
          $display("%0t: write with nothing owed: grid %0d seg %02h last %0b",
                   $time, got.grid, got.seg, got.last);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = pending_writes.pop_front();
          if (got !== want) begin
            $display({"%0t: write mismatch: expected grid %0d seg %02h last %0b, ",
                      "got grid %0d seg %02h last %0b"},
                     $time, want.grid, want.seg, want.last,
                     got.grid, got.seg, got.last);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_display_writes(action, value, dot_mask);
    end
    writes_outstanding <= pending_writes.size();
  end

endmodule

[verif/decimal_to_seven_segment_writer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_to_seven_segment_writer_test
// Feeds numbers to the display writer, first the edge cases by hand and then
// a random mix, with random gaps on both channels and one long output stall;
// the checker beside the block predicts and compares every display write.
// ----------------------------------------------------------------------------
module decimal_to_seven_segment_writer_test;
  import dssw_pkg::*;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               action    = 1'b0;
  logic [VALUE_W-1:0] value     = '0;
  logic [7:0]         dot_mask  = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [3:0]         grid_address;
  logic [7:0]         segments;
  logic               last_write;

  int unsigned mismatch_count;
  int unsigned writes_outstanding;
  int unsigned numbers_sent   = 0;
  bit          long_hold_done = 1'b0;

  always #5 clk = ~clk;

  decimal_to_seven_segment_writer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .value        (value),
    .dot_mask     (dot_mask),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .grid_address (grid_address),
    .segments     (segments),
    .last_write   (last_write)
  );

  display_write_check u_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .value              (value),
    .dot_mask           (dot_mask),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .grid_address       (grid_address),
    .segments           (segments),
    .last_write         (last_write),
    .mismatch_count     (mismatch_count),
    .writes_outstanding (writes_outstanding)
  );

  // offers one number and waits for the transaction, then maybe idles
  task automatic send_number(input logic act, input logic [VALUE_W-1:0] val,
                             input logic [7:0] dots);
    int unsigned r;
    int unsigned gap;
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    dot_mask <= dots;
    do @(posedge clk); while (!in_ready);
    numbers_sent++;
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 80);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned        r;
    int                 off;
    logic               act;
    logic [VALUE_W-1:0] val;
    logic [7:0]         dots;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_number(1'b0, 32'd0, 8'h00);
    send_number(1'b0, 32'd99999999, 8'hFF);
    send_number(1'b0, 32'd100000000, 8'hFF);
    send_number(1'b0, 32'hFFFFFFFF, 8'hFF);
    send_number(1'b0, 32'h80000000, 8'h0F);
    send_number(1'b0, 32'd12345678, 8'h55);
    send_number(1'b0, 32'd9876543, 8'h80);
    send_number(1'b0, 32'd10000000, 8'h01);
    send_number(1'b1, 32'd0, 8'hAA);
    send_number(1'b1, 32'd99999999, 8'hF0);
    send_number(1'b1, 32'd100000000, 8'h00);
    send_number(1'b1, 32'h7FFFFFFF, 8'hFF);
    send_number(1'b1, 32'hFFFFFFFF, 8'hFF);
    send_number(1'b1, 32'd0 - 32'd9999999, 8'hAA);
    send_number(1'b1, 32'd0 - 32'd10000000, 8'h55);
    send_number(1'b1, 32'h80000000, 8'hFF);
    send_number(1'b1, 32'd0 - 32'd1234567, 8'h7F);
    send_number(1'b1, 32'd0 - 32'd1000000, 8'h80);
    send_number(1'b0, 32'd5, 8'h00);

    for (int n = 0; n < 380; n++) begin
      r    = $urandom_range(0, 99);
      dots = 8'($urandom_range(0, 255));
      if (r < 30) begin
        act = 1'($urandom_range(0, 1));
        val = $urandom_range(0, 99999999);
      end else if (r < 55) begin
        act = 1'b1;
        val = 32'd0 - 32'($urandom_range(1, 9999999));
      end else if (r < 65) begin
        act = 1'b0;
        val = $urandom_range(0, 999);
      end else if (r < 75) begin
        // just either side of the overflow limits
        off = $urandom_range(0, 6);
        off = off - 3;
        act = 1'($urandom_range(0, 1));
        if (act) val = 32'd0 - 32'(9999999 + off);
        else val = 32'(99999999 + off);
      end else if (r < 85) begin
        act = 1'b1;
        val = 32'd0 - 32'($urandom_range(1, 999));
      end else begin
        act = 1'($urandom_range(0, 1));
        val = $urandom();
      end
      send_number(act, val, dots);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (writes_outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && writes_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // output side: random ready runs and gaps, plus one long stall mid-run
  initial begin
    int unsigned run;
    int unsigned r;
    int unsigned gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (numbers_sent >= 150 && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      run = $urandom_range(1, 24);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 70) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 60);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
